// File: rtl/core/sclt_pkg.sv
`default_nettype none
package sclt_pkg;

	// turn resolution, a power of two
	localparam int TICKS_PER_TURN = 1024;
	localparam int ANGLE_W = $clog2(TICKS_PER_TURN);
	localparam int ANGLE_OUT_W = 10;

	// octant slope: one eighth of a turn per unit ratio
	localparam int EIGHTH_SHIFT = ANGLE_W - 3;
	localparam int Q_W = EIGHTH_SHIFT + 1;
	localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

	localparam int SAMPLE_W = 12;
	localparam int AXIS_W = SAMPLE_W + 1;
	localparam int CENTER_W = 12;
	localparam int SPR_W = 7;
	localparam int LAPS_W = 16;
	localparam int SUM_W = 17;
	localparam int DIFF_W = ANGLE_W + 2;

	localparam logic [ANGLE_W-1:0] BASE_ZERO = '0;
	localparam logic [ANGLE_W-1:0] BASE_QUARTER = ANGLE_W'(TICKS_PER_TURN / 4);
	localparam logic [ANGLE_W-1:0] BASE_MINUS_QUARTER =
		ANGLE_W'(TICKS_PER_TURN - TICKS_PER_TURN / 4);
	localparam logic [ANGLE_W-1:0] BASE_HALF = ANGLE_W'(TICKS_PER_TURN / 2);

	localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(300);
	localparam logic [SPR_W-1:0] SPR_RESET = SPR_W'(5);

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic {
		REG_CENTER_OFFSET = 1'b0,
		REG_SAMPLES_PER_REPORT = 1'b1
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic report_due;
		logic out_blocked;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/sclt_regs.sv
`default_nettype none
module sclt_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [sclt_pkg::ADDR_W-1:0] paddr,
	input wire logic [sclt_pkg::DATA_W-1:0] pwdata,
	output logic [sclt_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [sclt_pkg::CENTER_W-1:0] center_offset,
	output logic [sclt_pkg::SPR_W-1:0] samples_per_report
);
	import sclt_pkg::*;

	logic [CENTER_W-1:0] center_q;
	logic [SPR_W-1:0] spr_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
			spr_q <= SPR_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER_OFFSET: center_q <= pwdata[CENTER_W-1:0];
				REG_SAMPLES_PER_REPORT: spr_q <= pwdata[SPR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_OFFSET: prdata = DATA_W'(center_q);
			REG_SAMPLES_PER_REPORT: prdata = DATA_W'(spr_q);
			default: prdata = '0;
		endcase
	end

	assign center_offset = center_q;
	assign samples_per_report = spr_q;

endmodule
`default_nettype wire

// File: rtl/core/sclt_ctrl.sv
`default_nettype none
module sclt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output sclt_pkg::cmd_t cmd,
	input wire sclt_pkg::sts_t sts
);
	import sclt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_UPDATE
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

	state_t state_q;
	logic [STEP_W-1:0] step_q;
	logic commit_ok;

	// a report can only be written once the output register is free
	assign commit_ok = !(sts.report_due && sts.out_blocked);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (commit_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.setup = (state_q == ST_SETUP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit = (state_q == ST_UPDATE) && commit_ok;
	end

endmodule
`default_nettype wire

// File: rtl/core/sclt_dp.sv
`default_nettype none
module sclt_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire sclt_pkg::cmd_t cmd,
	output sclt_pkg::sts_t sts,
	input wire logic [sclt_pkg::SAMPLE_W-1:0] sample_a,
	input wire logic [sclt_pkg::SAMPLE_W-1:0] sample_b,
	input wire logic [sclt_pkg::CENTER_W-1:0] center_offset,
	input wire logic [sclt_pkg::SPR_W-1:0] samples_per_report,
	output logic out_valid,
	input wire logic out_ready,
	output logic [sclt_pkg::ANGLE_OUT_W-1:0] angle,
	output logic signed [sclt_pkg::LAPS_W-1:0] lap_count,
	output logic signed [sclt_pkg::SUM_W-1:0] angle_change_sum
);
	import sclt_pkg::*;

	localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(TICKS_PER_TURN / 2);
	localparam logic signed [DIFF_W-1:0] TURN_S = DIFF_W'(TICKS_PER_TURN);
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// sample capture
	logic [SAMPLE_W-1:0] a_q, b_q;

	// divider and octant
	logic [SAMPLE_W-1:0] den_q, rem_q;
	logic [Q_W-1:0] dvd_q, quo_q;
	logic neg_q;
	logic [ANGLE_W-1:0] base_q;

	// tracking state
	logic [ANGLE_W-1:0] prev_q;
	logic primed_q;
	logic [LAPS_W-1:0] laps_q;
	logic signed [SUM_W-1:0] acc_q;
	logic [SPR_W-1:0] cnt_q;

	// output register
	logic out_valid_q;
	logic [ANGLE_OUT_W-1:0] angle_q;
	logic [LAPS_W-1:0] lap_q;
	logic signed [SUM_W-1:0] sum_q;

	// setup logic
	logic signed [AXIS_W-1:0] x, y, ax_full, ay_full, ax_s, ay_s;
	logic [SAMPLE_W-1:0] ax, ay, mag_d, den_d;
	logic neg_d;
	logic [ANGLE_W-1:0] base_d;

	assign x = $signed({1'b0, a_q}) - $signed({1'b0, center_offset});
	assign y = $signed({1'b0, b_q}) - $signed({1'b0, center_offset});
	assign ax_full = x[AXIS_W-1] ? -x : x;
	assign ay_full = y[AXIS_W-1] ? -y : y;
	assign ax = ax_full[SAMPLE_W-1:0];
	assign ay = ay_full[SAMPLE_W-1:0];
	assign ax_s = $signed({1'b0, ax});
	assign ay_s = $signed({1'b0, ay});

	// octant pick: numerator magnitude, divisor, result sign and base angle
	always_comb begin
		priority if (x >= ay_s) begin
			mag_d = ay;
			den_d = ax;
			neg_d = y[AXIS_W-1];
			base_d = BASE_ZERO;
		end else if (y >= ax_s) begin
			mag_d = ax;
			den_d = ay;
			neg_d = !x[AXIS_W-1] && (x != '0);
			base_d = BASE_QUARTER;
		end else if (-y >= ax_s) begin
			mag_d = ax;
			den_d = ay;
			neg_d = x[AXIS_W-1];
			base_d = BASE_MINUS_QUARTER;
		end else begin
			mag_d = ay;
			den_d = ax;
			neg_d = !y[AXIS_W-1] && (y != '0);
			base_d = BASE_HALF;
		end
	end

	// restoring divider step
	logic [SAMPLE_W:0] shifted, trial;
	logic ge;

	assign shifted = {rem_q, dvd_q[Q_W-1]};
	assign ge = shifted >= {1'b0, den_q};
	assign trial = shifted - {1'b0, den_q};

	// angle and lap update
	logic [ANGLE_W-1:0] q_ext, theta;
	logic signed [DIFF_W-1:0] diff, change;
	logic lap_up, lap_down;
	logic signed [SUM_W:0] sum_w;
	logic signed [SUM_W-1:0] sum_sat;
	logic [SPR_W-1:0] cnt_next;

	assign q_ext = ANGLE_W'(quo_q);
	assign theta = base_q + (neg_q ? -q_ext : q_ext);
	assign diff = $signed(DIFF_W'(theta)) - $signed(DIFF_W'(prev_q));
	assign lap_up = diff < -HALF_S;
	assign lap_down = diff > HALF_S;

	always_comb begin
		priority if (lap_up) change = diff + TURN_S;
		else if (lap_down) change = diff - TURN_S;
		else change = diff;
	end

	assign sum_w = (SUM_W+1)'(acc_q) + (SUM_W+1)'(change);
	always_comb begin
		if (sum_w[SUM_W] != sum_w[SUM_W-1]) sum_sat = sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
		else sum_sat = sum_w[SUM_W-1:0];
	end

	assign cnt_next = cnt_q + SPR_W'(1);
	assign sts.report_due = primed_q && (cnt_next >= samples_per_report);
	assign sts.out_blocked = out_valid_q && !out_ready;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= sample_a;
			b_q <= sample_b;
		end
		if (cmd.setup) begin
			den_q <= (den_d == '0) ? SAMPLE_W'(1) : den_d;
			rem_q <= mag_d >> 1;
			dvd_q <= {mag_d[0], {(Q_W-1){1'b0}}};
			quo_q <= '0;
			neg_q <= neg_d;
			base_q <= base_d;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
		if (cmd.commit && sts.report_due) begin
			angle_q <= ANGLE_OUT_W'(theta);
			lap_q <= laps_q + (lap_up ? LAPS_W'(1) : '0) - (lap_down ? LAPS_W'(1) : '0);
			sum_q <= sum_sat;
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			primed_q <= 1'b0;
			laps_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.commit) begin
				prev_q <= theta;
				primed_q <= 1'b1;
				if (primed_q) begin
					laps_q <= laps_q + (lap_up ? LAPS_W'(1) : '0)
						- (lap_down ? LAPS_W'(1) : '0);
					if (sts.report_due) begin
						acc_q <= '0;
						cnt_q <= '0;
						out_valid_q <= 1'b1;
					end else begin
						acc_q <= sum_sat;
						cnt_q <= cnt_next;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign angle = angle_q;
	assign lap_count = $signed(lap_q);
	assign angle_change_sum = sum_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && sts.report_due |-> !(out_valid_q && !out_ready))
		else $error("report written over a pending one");

	a_report_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && sts.report_due |=> out_valid_q && acc_q == '0 && cnt_q == '0)
		else $error("report did not reach the output or sum not cleared");

	a_unprimed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !primed_q |=> cnt_q == $past(cnt_q) && laps_q == $past(laps_q)
			&& primed_q)
		else $error("priming sample changed tracking state");

endmodule
`default_nettype wire

// File: rtl/core/sincos_angle_lap_tracker.sv
`default_nettype none
// Angle and lap tracker for a pair of analog sin/cos sensors. Each request is one pair of
// 12-bit ADC samples; the center_offset register is subtracted from both and a piecewise
// atan2 by octant (truncating division) gives an angle in ticks of a 1024-tick turn. Jumps
// larger than half a turn count a lap, unwrapped changes are summed, and after every
// samples_per_report samples one report (angle, lap count, summed change) is delivered.
// The first sample after reset only primes the previous angle. A sample passes through a
// capture step (the accepting one), an octant setup, eight iterations of the restoring
// divider (one quotient bit per cycle) and an update; no new request is taken until the
// update is done. The update holds while a report is due and the previous one has not been
// taken. The output register lets the next sample be accepted while a report waits.
// Registers sit on the APB port at 0x0 (center) and 0x4 (samples per report); the user
// must write them only while idle, the block itself does not enforce it.
module sincos_angle_lap_tracker (
	input wire logic clk,
	input wire logic arst_n,
	// configuration port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [sclt_pkg::ADDR_W-1:0] paddr,
	input wire logic [sclt_pkg::DATA_W-1:0] pwdata,
	output logic [sclt_pkg::DATA_W-1:0] prdata,
	output logic pready,
	// sample requests
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [sclt_pkg::SAMPLE_W-1:0] sample_a,
	input wire logic [sclt_pkg::SAMPLE_W-1:0] sample_b,
	// report requests
	output logic out_valid,
	input wire logic out_ready,
	output logic [sclt_pkg::ANGLE_OUT_W-1:0] angle,
	output logic signed [sclt_pkg::LAPS_W-1:0] lap_count,
	output logic signed [sclt_pkg::SUM_W-1:0] angle_change_sum
);
	import sclt_pkg::*;

	logic [CENTER_W-1:0] center_offset;
	logic [SPR_W-1:0] samples_per_report;
	cmd_t cmd;
	sts_t sts;

	// register file
	sclt_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.center_offset(center_offset),
		.samples_per_report(samples_per_report)
	);

	// sequencer: capture, setup, divide, update
	sclt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.sts(sts)
	);

	// octant atan2, divider, lap tracking and output register
	sclt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.center_offset(center_offset),
		.samples_per_report(samples_per_report),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle(angle),
		.lap_count(lap_count),
		.angle_change_sum(angle_change_sum)
	);

endmodule
`default_nettype wire

// File: tb/tb.sv
module tb;
	import sclt_pkg::*;

	// run limit, far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// cycles to let a sample that gives no report finish before touching registers
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam longint EIGHTH = TICKS_PER_TURN / 8;
	localparam longint QUARTER = TICKS_PER_TURN / 4;
	localparam longint HALF = TICKS_PER_TURN / 2;
	localparam int SUM_MAX = 65535;
	localparam int SUM_MIN = -65536;
	localparam real TWO_PI = 6.283185307179586;

	typedef struct {
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
	} sample_t;

	typedef struct {
		logic [ANGLE_OUT_W-1:0] angle;
		logic [LAPS_W-1:0] laps;
		logic [SUM_W-1:0] sum;
	} report_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	// configuration port, idle until a register write
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// sample request side
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_W-1:0] sample_a = '0;
	logic [SAMPLE_W-1:0] sample_b = '0;

	// report request side
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ANGLE_OUT_W-1:0] angle;
	logic signed [LAPS_W-1:0] lap_count;
	logic signed [SUM_W-1:0] angle_change_sum;

	sincos_angle_lap_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle(angle),
		.lap_count(lap_count),
		.angle_change_sum(angle_change_sum)
	);

	// samples waiting for the driver, reports waiting for the dut
	sample_t samples_to_send[$];
	report_t expected_reports[$];

	// tracker copy: registers and state as the dut should hold them
	logic [CENTER_W-1:0] center_cfg = CENTER_RESET;
	logic [SPR_W-1:0] spr_cfg = SPR_RESET;
	logic [ANGLE_W-1:0] last_angle = '0;
	logic primed = 1'b0;
	logic [LAPS_W-1:0] laps = '0;
	int change_sum = 0;
	logic [SPR_W-1:0] sample_count = '0;

	// bookkeeping
	int errors = 0;
	int samples_sent = 0;
	int reports_seen = 0;
	int laps_up = 0;
	int laps_down = 0;
	int settings_used = 0;
	int cycle_count = 0;
	logic no_idle = 1'b0;

	// shaft motion used to build well-formed sample streams
	real shaft_pos = 0.0;
	real shaft_rad = 1500.0;
	int shaft_dir = 1;

	// driver and monitor idling
	int send_gap = 0;
	int stall_left = 0;
	int long_hold_left = 0;
	logic long_hold_done = 1'b0;

	// hand-picked samples for a center of 2048: axes, diagonals, exact half turns,
	// one-code offsets and negative quotients
	int unsigned probe_a[24] = '{2048, 2048, 4095, 3000, 2048, 1000, 0, 1000,
		2048, 3000, 4095, 4095, 4095, 3000, 0, 4095, 0, 0, 4095, 2049, 2047,
		2048, 2048, 3000};
	int unsigned probe_b[24] = '{2048, 2048, 2048, 3000, 4095, 3096, 2048, 1000,
		0, 1096, 2047, 2049, 2047, 1096, 0, 4095, 0, 4095, 0, 2048, 2048,
		2049, 2047, 1500};

	// one sample through the tracker copy; pushes a report when one is due
	task automatic track_sample(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
		longint x, y, ax, ay, t, chg, sum;
		report_t r;
		x = longint'(a) - longint'(center_cfg);
		y = longint'(b) - longint'(center_cfg);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		// octant pick, divisions truncate toward zero
		if (x >= ay)
			t = (x == 0) ? 0 : (EIGHTH * y) / x;
		else if (y >= ax)
			t = QUARTER + (-EIGHTH * x) / y;
		else if (-y >= ax)
			t = -QUARTER + (-EIGHTH * x) / y;
		else
			t = HALF + (EIGHTH * y) / x;
		if (t < 0)
			t += TICKS_PER_TURN;
		// first sample after reset only sets the previous angle
		if (!primed) begin
			last_angle = ANGLE_W'(t);
			primed = 1'b1;
			return;
		end
		// a jump over half a turn is a lap crossing
		chg = t - longint'(last_angle);
		if (chg < -HALF) begin
			laps = laps + 1'b1;
			chg += TICKS_PER_TURN;
			laps_up++;
		end else if (chg > HALF) begin
			laps = laps - 1'b1;
			chg -= TICKS_PER_TURN;
			laps_down++;
		end
		last_angle = ANGLE_W'(t);
		sum = longint'(change_sum) + chg;
		if (sum > SUM_MAX)
			sum = SUM_MAX;
		if (sum < SUM_MIN)
			sum = SUM_MIN;
		change_sum = int'(sum);
		sample_count = sample_count + 1'b1;
		if (sample_count < spr_cfg)
			return;
		r.angle = ANGLE_OUT_W'(t);
		r.laps = laps;
		r.sum = SUM_W'(change_sum);
		expected_reports.push_back(r);
		change_sum = 0;
		sample_count = '0;
	endtask

	// register write: setup cycle, access cycle, then back to idle and read back
	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] want_rd;
		want_rd = '0;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER_OFFSET: begin
				center_cfg = value[CENTER_W-1:0];
				want_rd = DATA_W'(value[CENTER_W-1:0]);
			end
			REG_SAMPLES_PER_REPORT: begin
				spr_cfg = value[SPR_W-1:0];
				want_rd = DATA_W'(value[SPR_W-1:0]);
			end
		endcase
		@(negedge clk);
		// address still points at the register just written
		if (!pready || prdata !== want_rd) begin
			$error("prdata: expected %0d, got %0d", want_rd, prdata);
			errors++;
		end
	endtask

	// wait until every sample is in and every report is out, then let the pipe empty
	task automatic wait_drained();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] axis_code(input logic [CENTER_W-1:0] ctr,
		input real offset);
		real v;
		v = real'(ctr) + offset;
		if (v < 0.0)
			v = 0.0;
		if (v > 4095.0)
			v = 4095.0;
		return SAMPLE_W'($rtoi(v + 0.5));
	endfunction

	// noise: full-range codes, rail codes, or codes within a few steps of center
	function automatic logic [SAMPLE_W-1:0] noise_code(input logic [CENTER_W-1:0] ctr);
		int v;
		v = 0;
		case ($urandom_range(0, 3))
			0: v = int'($urandom_range(0, 4095));
			1: v = 0;
			2: v = 4095;
			default: begin
				v = int'(ctr) + int'($urandom_range(0, 6)) - 3;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end
		endcase
		return SAMPLE_W'(v);
	endfunction

	// mostly a turning shaft around the configured center, with noise and sudden jumps
	task automatic queue_shaft_samples(input int count, input logic [CENTER_W-1:0] ctr);
		sample_t s;
		int pick;
		real ang;
		for (int i = 0; i < count; i++) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 12) begin
				s.a = noise_code(ctr);
				s.b = noise_code(ctr);
			end else begin
				if (pick < 16) begin
					// broken stream: arbitrary jump of the shaft
					shaft_pos += real'(int'($urandom_range(0, 1023)));
				end else begin
					if ($urandom_range(0, 39) == 0)
						shaft_dir = -shaft_dir;
					if ($urandom_range(0, 29) == 0)
						shaft_rad = real'(int'($urandom_range(2, 2100)));
					shaft_pos += real'(shaft_dir * int'($urandom_range(0, 140)));
				end
				ang = TWO_PI * shaft_pos / real'(TICKS_PER_TURN);
				s.a = axis_code(ctr, shaft_rad * $cos(ang));
				s.b = axis_code(ctr, shaft_rad * $sin(ang));
			end
			samples_to_send.push_back(s);
		end
	endtask

	// driver: offers queued samples, holds them until taken, idles in bursts
	always @(posedge clk) begin : sample_driver
		sample_t next_item;
		logic offer;
		if (arst_n) begin
			// request taken at this edge goes through the tracker copy
			if (in_valid && in_ready) begin
				track_sample(sample_a, sample_b);
				samples_sent++;
			end
			offer = 1'b0;
			if (in_valid && !in_ready) begin
				// still waiting, keep the same request up
				offer = 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
			end else if (samples_to_send.size() > 0) begin
				if (!no_idle && $urandom_range(0, 5) == 0) begin
					// idle burst whose length send_gap sets, this cycle included
					send_gap = int'($urandom_range(0, 15));
				end else begin
					next_item = samples_to_send.pop_front();
					sample_a <= next_item.a;
					sample_b <= next_item.b;
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// monitor: checks each report against the oldest expected one, stalls in bursts
	always @(posedge clk) begin : report_monitor
		report_t want;
		logic take;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					$error("unexpected report: angle %0d lap_count %0d angle_change_sum %0d",
						angle, lap_count, angle_change_sum);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					if (angle !== want.angle) begin
						$error("angle: expected %0d, got %0d", want.angle, angle);
						errors++;
					end
					if (lap_count !== want.laps) begin
						$error("lap_count: expected %0d, got %0d", $signed(want.laps),
							lap_count);
						errors++;
					end
					if (angle_change_sum !== want.sum) begin
						$error("angle_change_sum: expected %0d, got %0d",
							$signed(want.sum), angle_change_sum);
						errors++;
					end
				end
			end
			take = 1'b0;
			if (long_hold_left > 0) begin
				long_hold_left--;
			end else if (!long_hold_done && reports_seen >= 12) begin
				// one long hold-off so the dut backs up and stalls its input
				long_hold_done = 1'b1;
				long_hold_left = LONG_HOLD_CYCLES - 1;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				stall_left = int'($urandom_range(0, 15));
			end else begin
				take = 1'b1;
			end
			out_ready <= take;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// stimulus sequence: directed probes, then register settings with random streams
	int fixed_center[6] = '{0, 4095, 2048, 1234, 300, 2048};
	int fixed_spr[6] = '{1, 64, 3, 0, 5, 127};
	int fixed_count[6] = '{110, 100, 90, 90, 110, 300};

	initial begin : run_sequence
		sample_t s;
		logic [CENTER_W-1:0] ctr;
		logic [SPR_W-1:0] spr;
		int count;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed probes, one report per counted sample
		cfg_write(REG_CENTER_OFFSET, 2048);
		cfg_write(REG_SAMPLES_PER_REPORT, 1);
		settings_used++;
		for (int i = 0; i < 24; i++) begin
			s.a = SAMPLE_W'(probe_a[i]);
			s.b = SAMPLE_W'(probe_b[i]);
			samples_to_send.push_back(s);
		end
		wait_drained();

		// fixed settings first (rails, zero and max threshold, reset values), then random
		for (int p = 0; p < 14; p++) begin
			if (p < 6) begin
				ctr = CENTER_W'(fixed_center[p]);
				spr = SPR_W'(fixed_spr[p]);
				count = fixed_count[p];
			end else begin
				if ($urandom_range(0, 1) == 0)
					ctr = CENTER_W'($urandom_range(1448, 2648));
				else
					ctr = CENTER_W'($urandom_range(0, 4095));
				spr = SPR_W'($urandom_range(1, 12));
				count = 106;
			end
			// last stretch runs with no idling on either side
			if (p == 13)
				no_idle = 1'b1;
			cfg_write(REG_CENTER_OFFSET, DATA_W'(ctr));
			cfg_write(REG_SAMPLES_PER_REPORT, DATA_W'(spr));
			settings_used++;
			queue_shaft_samples(count, ctr);
			wait_drained();
		end

		if (expected_reports.size() != 0)
			errors++;
		$display("covered %0d samples and %0d reports over %0d register settings",
			samples_sent, reports_seen, settings_used);
		$display("lap crossings seen: %0d forward, %0d backward", laps_up, laps_down);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/sclt_pkg.sv
rtl/core/sclt_regs.sv
rtl/core/sclt_ctrl.sv
rtl/core/sclt_dp.sv
rtl/core/sincos_angle_lap_tracker.sv
tb/tb.sv
